// File: rtl/stereo_echo_delay_with_resonance_defines.svh
// ----------------------------------------------------------------------------
// stereo echo delay assertion macros
// shared property forms for the checker file
// ----------------------------------------------------------------------------
`ifndef STEREO_ECHO_DELAY_WITH_RESONANCE_DEFINES_SVH
`define STEREO_ECHO_DELAY_WITH_RESONANCE_DEFINES_SVH

// same-cycle implication
`define SEDR_ASSERT_IMP(lbl, clk_s, rst_n, ant, cons, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n) (ant) |-> (cons)) else $error(msg);

// next-cycle implication
`define SEDR_ASSERT_NXT(lbl, clk_s, rst_n, ant, cons, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n) (ant) |=> (cons)) else $error(msg);

`endif

// File: rtl/sedr_pkg.sv
// ----------------------------------------------------------------------------
// sedr_pkg
// types, register codes and constants of the stereo echo delay
// ----------------------------------------------------------------------------
package sedr_pkg;

	localparam int HISTORY_DEPTH_DEF = 1024;
	localparam int ECHO_DEPTH_DEF    = 8192;
	localparam int MAX_TAPS_DEF      = 16;

	localparam int SAMPLE_W   = 16;
	localparam int GAIN_W     = 17;
	localparam int COEF_W     = 16;
	localparam int SPAN_W     = 10;
	localparam int STEPS_W    = 4;
	localparam int DLEN_W     = 14;
	localparam int DIST_W     = 11;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	localparam cfg_idx_t REG_FEEDBACK_GAIN = 3'd0;
	localparam cfg_idx_t REG_RESO_GAIN     = 3'd1;
	localparam cfg_idx_t REG_RESO_SPAN     = 3'd2;
	localparam cfg_idx_t REG_RESO_STEPS    = 3'd3;
	localparam cfg_idx_t REG_DELAY_LENGTH  = 3'd4;

	localparam logic [COEF_W-1:0] FEEDBACK_RST = 16'd32768;
	localparam logic [DLEN_W-1:0] DLEN_RST     = 14'd8192;
	localparam logic [GAIN_W-1:0] GAIN_ONE     = 17'h10000;

	// smoother coefficients 0.3, 0.7, 0.1, 0.2 in q0.16
	localparam logic [COEF_W-1:0] K_03 = 16'd19661;
	localparam logic [COEF_W-1:0] K_07 = 16'd45875;
	localparam logic [COEF_W-1:0] K_01 = 16'd6554;
	localparam logic [COEF_W-1:0] K_02 = 16'd13107;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DIV,
		ST_TAP,
		ST_DRAIN,
		ST_SMOOTH,
		ST_FIN
	} seq_state_t;

	typedef enum logic [2:0] {
		SM_X03,
		SM_F07,
		SM_X01,
		SM_F02,
		SM_S07,
		SM_FB
	} sm_step_t;

	typedef struct packed {
		logic clr;
		logic mac_en;
	} lane_ctrl_t;

	function automatic int acc_width(input int max_taps);
		return 34 + $clog2(max_taps);
	endfunction

endpackage

// File: rtl/sedr_tap_lane.sv
// ----------------------------------------------------------------------------
// sedr_tap_lane
// one channel of the resonance tap sum: multiply history sample by tap gain
// and accumulate, rounded sum out in q1.15 plus headroom
// ----------------------------------------------------------------------------
module sedr_tap_lane #(
	parameter int MAX_TAPS = sedr_pkg::MAX_TAPS_DEF
) (
	input  logic                                          clk,
	input  logic                                          arst_n,
	input  sedr_pkg::lane_ctrl_t                          ctrl,
	input  logic signed [sedr_pkg::SAMPLE_W-1:0]          sample,
	input  logic        [sedr_pkg::GAIN_W-1:0]            gain,
	output logic signed [sedr_pkg::acc_width(MAX_TAPS)-17:0] tap_sum
);

	localparam int ACC_W  = sedr_pkg::acc_width(MAX_TAPS);
	localparam int PROD_W = sedr_pkg::SAMPLE_W + sedr_pkg::GAIN_W + 1;

	logic signed [PROD_W-1:0] prod;
	logic signed [ACC_W-1:0]  acc_q;
	logic signed [ACC_W-1:0]  acc_rnd;

	assign prod    = sample * $signed({1'b0, gain});
	assign acc_rnd = acc_q + $signed(ACC_W'(32768));
	assign tap_sum = $signed(acc_rnd[ACC_W-1:16]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (ctrl.clr) begin
			acc_q <= '0;
		end else if (ctrl.mac_en) begin
			acc_q <= acc_q + ACC_W'(prod);
		end
	end

endmodule

// File: rtl/sedr_smoother.sv
// ----------------------------------------------------------------------------
// sedr_smoother
// two-pole smoother shared by left then right, one multiply-add per cycle,
// merges the lane tap sums into the new echo values
// ----------------------------------------------------------------------------
module sedr_smoother #(
	parameter int MAX_TAPS = sedr_pkg::MAX_TAPS_DEF
) (
	input  logic                                             clk,
	input  logic                                             arst_n,
	input  logic                                             start,
	input  logic        [sedr_pkg::COEF_W-1:0]               feedback_gain,
	input  logic signed [sedr_pkg::SAMPLE_W-1:0]             x_left,
	input  logic signed [sedr_pkg::SAMPLE_W-1:0]             x_right,
	input  logic signed [sedr_pkg::acc_width(MAX_TAPS)-17:0] reso_left,
	input  logic signed [sedr_pkg::acc_width(MAX_TAPS)-17:0] reso_right,
	output logic                                             done,
	output logic signed [sedr_pkg::SAMPLE_W-1:0]             echo_left,
	output logic signed [sedr_pkg::SAMPLE_W-1:0]             echo_right
);

	localparam int TSUM_W = sedr_pkg::acc_width(MAX_TAPS) - 16;
	localparam int SACC_W = 43;
	localparam int FBR_W  = SACC_W - 24;
	localparam int EW     = ((FBR_W > TSUM_W) ? FBR_W : TSUM_W) + 1;

	sedr_pkg::sm_step_t step_q, step_d;
	logic                          busy_q;
	logic                          ch_q;
	logic signed [23:0]            first_q;
	logic signed [23:0]            second_q;
	logic signed [SACC_W-1:0]      acc_q;
	logic signed [15:0]            el_q;
	logic signed [15:0]            er_q;

	logic signed [15:0]            x_cur;
	logic signed [TSUM_W-1:0]      reso_cur;
	logic signed [23:0]            x23;
	logic        [15:0]            coef;
	logic signed [23:0]            opnd;
	logic                          load;
	logic signed [40:0]            prod;
	logic signed [SACC_W-1:0]      sum;
	logic signed [SACC_W-1:0]      rnd16_t;
	logic signed [SACC_W-17:0]     rnd16;
	logic signed [23:0]            sat24;
	logic signed [SACC_W-1:0]      rnd24_t;
	logic signed [FBR_W-1:0]       rnd24;
	logic signed [EW-1:0]          e_sum;
	logic signed [15:0]            e_sat;

	assign x_cur    = ch_q ? x_right : x_left;
	assign reso_cur = ch_q ? reso_right : reso_left;
	assign x23      = $signed({x_cur, 8'h00});

	always_comb begin
		coef = sedr_pkg::K_03;
		opnd = x23;
		load = 1'b1;
		unique case (step_q)
			sedr_pkg::SM_X03: begin
				coef = sedr_pkg::K_03;
				opnd = x23;
				load = 1'b1;
			end
			sedr_pkg::SM_F07: begin
				coef = sedr_pkg::K_07;
				opnd = first_q;
				load = 1'b0;
			end
			sedr_pkg::SM_X01: begin
				coef = sedr_pkg::K_01;
				opnd = x23;
				load = 1'b1;
			end
			sedr_pkg::SM_F02: begin
				coef = sedr_pkg::K_02;
				opnd = first_q;
				load = 1'b0;
			end
			sedr_pkg::SM_S07: begin
				coef = sedr_pkg::K_07;
				opnd = second_q;
				load = 1'b0;
			end
			sedr_pkg::SM_FB: begin
				coef = feedback_gain;
				opnd = second_q;
				load = 1'b1;
			end
			default: begin
				coef = sedr_pkg::K_03;
				opnd = x23;
				load = 1'b1;
			end
		endcase
	end

	always_comb begin
		unique case (step_q)
			sedr_pkg::SM_X03: step_d = sedr_pkg::SM_F07;
			sedr_pkg::SM_F07: step_d = sedr_pkg::SM_X01;
			sedr_pkg::SM_X01: step_d = sedr_pkg::SM_F02;
			sedr_pkg::SM_F02: step_d = sedr_pkg::SM_S07;
			sedr_pkg::SM_S07: step_d = sedr_pkg::SM_FB;
			default:          step_d = sedr_pkg::SM_X03;
		endcase
	end

	assign prod    = $signed({1'b0, coef}) * opnd;
	assign sum     = (load ? $signed(SACC_W'(0)) : acc_q) + SACC_W'(prod);
	assign rnd16_t = sum + $signed(SACC_W'(32768));
	assign rnd16   = $signed(rnd16_t[SACC_W-1:16]);
	assign rnd24_t = sum + $signed(SACC_W'(8388608));
	assign rnd24   = $signed(rnd24_t[SACC_W-1:24]);
	assign e_sum   = EW'(rnd24) + EW'(reso_cur);

	always_comb begin
		if (rnd16 > 8388607) begin
			sat24 = 24'sh7fffff;
		end else if (rnd16 < -8388608) begin
			sat24 = 24'sh800000;
		end else begin
			sat24 = rnd16[23:0];
		end
		if (e_sum > 32767) begin
			e_sat = 16'sh7fff;
		end else if (e_sum < -32768) begin
			e_sat = 16'sh8000;
		end else begin
			e_sat = e_sum[15:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			ch_q     <= 1'b0;
			step_q   <= sedr_pkg::SM_X03;
			first_q  <= '0;
			second_q <= '0;
			acc_q    <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			ch_q   <= 1'b0;
			step_q <= sedr_pkg::SM_X03;
		end else if (busy_q) begin
			acc_q  <= sum;
			step_q <= step_d;
			if (step_q == sedr_pkg::SM_F07) begin
				first_q <= sat24;
			end
			if (step_q == sedr_pkg::SM_S07) begin
				second_q <= sat24;
			end
			if (step_q == sedr_pkg::SM_FB) begin
				ch_q <= 1'b1;
				if (ch_q) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (busy_q && step_q == sedr_pkg::SM_FB) begin
			if (ch_q) begin
				er_q <= e_sat;
			end else begin
				el_q <= e_sat;
			end
		end
	end

	assign done       = busy_q && ch_q && (step_q == sedr_pkg::SM_FB);
	assign echo_left  = el_q;
	assign echo_right = er_q;

endmodule

// File: rtl/stereo_echo_delay_with_resonance.sv
// ----------------------------------------------------------------------------
// stereo_echo_delay_with_resonance
// n = taps summed per item (1..16); the shared gain multiplier walks the taps one
// per cycle, and the smoother runs its steps on one multiplier; s_tready is high
// only in idle, so a new item is taken only once the last one is through
// reset: asynchronous, then a clearing pass over max(HISTORY_DEPTH, ECHO_DEPTH)
// addresses (8192 by default) zeroes both rings before the first item is taken
// ----------------------------------------------------------------------------
module stereo_echo_delay_with_resonance #(
	parameter int HISTORY_DEPTH = sedr_pkg::HISTORY_DEPTH_DEF,
	parameter int ECHO_DEPTH    = sedr_pkg::ECHO_DEPTH_DEF,
	parameter int MAX_TAPS      = sedr_pkg::MAX_TAPS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// src_left, src_right, mix_left, mix_right
	input  logic [63:0]                       s_tdata,
	input  logic                              s_tlast,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// out_left, out_right
	output logic [31:0]                       m_tdata,
	output logic                              m_tlast,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [sedr_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [sedr_pkg::CFG_DATA_W-1:0]   cfg_data
);

	localparam int HAW    = $clog2(HISTORY_DEPTH);
	localparam int EAW    = $clog2(ECHO_DEPTH);
	localparam int CLR_N  = (HISTORY_DEPTH > ECHO_DEPTH) ? HISTORY_DEPTH : ECHO_DEPTH;
	localparam int CLR_W  = $clog2(CLR_N);
	localparam int TSUM_W = sedr_pkg::acc_width(MAX_TAPS) - 16;
	localparam int TAP_CW = $clog2(MAX_TAPS + 1);
	localparam int DIST_W = sedr_pkg::DIST_W;
	localparam int DX_W   = HAW + DIST_W;
	localparam int PW     = ((EAW > sedr_pkg::DLEN_W) ? EAW : sedr_pkg::DLEN_W) + 1;
	localparam int GAIN_W = sedr_pkg::GAIN_W;

	// configuration
	logic [15:0]                    feedback_gain_q;
	logic [15:0]                    reso_gain_q;
	logic [sedr_pkg::SPAN_W-1:0]    reso_span_q;
	logic [sedr_pkg::STEPS_W-1:0]   reso_steps_q;
	logic [sedr_pkg::DLEN_W-1:0]    delay_length_q;

	sedr_pkg::seq_state_t state_q, state_d;
	sedr_pkg::lane_ctrl_t lane_ctrl;

	logic [CLR_W-1:0]  clr_cnt_q;
	logic              clr_last;
	logic [HAW-1:0]    sp_q;
	logic [EAW-1:0]    ep_q;
	logic [EAW-1:0]    ep_inc;
	logic [3:0]        div_cnt_q;
	logic [4:0]        rem_q;
	logic [8:0]        quot_q;
	logic [DIST_W-1:0] step_q;
	logic [DIST_W-1:0] dist_q;
	logic [TAP_CW-1:0] taps_q;
	logic              rd_valid_s1;
	logic              m_tvalid_q;

	logic [GAIN_W-1:0] gain_q;
	logic [GAIN_W-1:0] gain_s1;
	logic [GAIN_W-1:0] gain_nx;
	logic [32:0]       gain_prod;
	logic [33:0]       gain_sum;

	logic signed [15:0] mix_l_q;
	logic signed [15:0] mix_r_q;
	logic               last_q;
	logic [31:0]        m_tdata_q;
	logic               m_tlast_q;

	// divider
	logic [4:0] div_d;
	logic [5:0] div_sh;
	logic       div_ge;
	logic [5:0] div_rem;

	logic              tap_go;
	logic [DX_W-1:0]   dist_x;
	logic              accept;
	logic              sm_start;
	logic              sm_done;
	logic              fin_load;

	// memories
	logic [31:0] hist_mem [HISTORY_DEPTH];
	logic [31:0] echo_mem [ECHO_DEPTH];
	logic        hist_we;
	logic [HAW-1:0] hist_wa;
	logic [31:0] hist_wd;
	logic        hist_re;
	logic [HAW-1:0] hist_ra;
	logic [31:0] hist_rd_q;
	logic        echo_we;
	logic [EAW-1:0] echo_wa;
	logic [31:0] echo_wd;
	logic        echo_re;
	logic [31:0] echo_rd_q;

	logic signed [TSUM_W-1:0] tsum_l;
	logic signed [TSUM_W-1:0] tsum_r;
	logic signed [15:0]       el;
	logic signed [15:0]       er;
	logic signed [16:0]       out_l_sum;
	logic signed [16:0]       out_r_sum;
	logic [15:0]              out_l;
	logic [15:0]              out_r;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			feedback_gain_q <= sedr_pkg::FEEDBACK_RST;
			reso_gain_q     <= '0;
			reso_span_q     <= '0;
			reso_steps_q    <= '0;
			delay_length_q  <= sedr_pkg::DLEN_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				sedr_pkg::REG_FEEDBACK_GAIN: feedback_gain_q <= cfg_data;
				sedr_pkg::REG_RESO_GAIN:     reso_gain_q     <= cfg_data;
				sedr_pkg::REG_RESO_SPAN:     reso_span_q     <= cfg_data[sedr_pkg::SPAN_W-1:0];
				sedr_pkg::REG_RESO_STEPS:    reso_steps_q    <= cfg_data[sedr_pkg::STEPS_W-1:0];
				sedr_pkg::REG_DELAY_LENGTH:  delay_length_q  <= cfg_data[sedr_pkg::DLEN_W-1:0];
				default: ;
			endcase
		end
	end

	assign clr_last = (clr_cnt_q == CLR_W'(CLR_N - 1));
	assign accept   = s_tvalid && s_tready;

	assign div_d   = {1'b0, reso_steps_q} + 5'd1;
	assign div_sh  = {rem_q, reso_span_q[div_cnt_q]};
	assign div_ge  = (div_sh >= {1'b0, div_d});
	assign div_rem = div_ge ? (div_sh - {1'b0, div_d}) : div_sh;

	assign tap_go    = (dist_q <= {1'b0, reso_span_q}) && (taps_q != TAP_CW'(MAX_TAPS));
	assign gain_prod = gain_q * reso_gain_q;
	assign gain_sum  = {1'b0, gain_prod} + 34'd32768;
	assign gain_nx   = gain_sum[32:16];
	assign dist_x    = DX_W'(dist_q);
	assign ep_inc    = ep_q + 1'b1;

	always_comb begin
		state_d       = state_q;
		s_tready      = 1'b0;
		lane_ctrl.clr = 1'b0;
		sm_start      = 1'b0;
		fin_load      = 1'b0;
		unique case (state_q)
			sedr_pkg::ST_CLEAR: begin
				if (clr_last) begin
					state_d = sedr_pkg::ST_IDLE;
				end
			end
			sedr_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					state_d = sedr_pkg::ST_DIV;
				end
			end
			sedr_pkg::ST_DIV: begin
				if (div_cnt_q == 4'd0) begin
					lane_ctrl.clr = 1'b1;
					state_d       = sedr_pkg::ST_TAP;
				end
			end
			sedr_pkg::ST_TAP: begin
				if (!tap_go) begin
					state_d = sedr_pkg::ST_DRAIN;
				end
			end
			sedr_pkg::ST_DRAIN: begin
				sm_start = 1'b1;
				state_d  = sedr_pkg::ST_SMOOTH;
			end
			sedr_pkg::ST_SMOOTH: begin
				if (sm_done) begin
					state_d = sedr_pkg::ST_FIN;
				end
			end
			sedr_pkg::ST_FIN: begin
				if (!m_tvalid_q || m_tready) begin
					fin_load = 1'b1;
					state_d  = sedr_pkg::ST_IDLE;
				end
			end
			default: state_d = sedr_pkg::ST_CLEAR;
		endcase
		lane_ctrl.mac_en = rd_valid_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= sedr_pkg::ST_CLEAR;
			clr_cnt_q   <= '0;
			sp_q        <= '0;
			ep_q        <= '0;
			div_cnt_q   <= '0;
			taps_q      <= '0;
			rd_valid_s1 <= 1'b0;
			m_tvalid_q  <= 1'b0;
		end else begin
			state_q     <= state_d;
			rd_valid_s1 <= (state_q == sedr_pkg::ST_TAP) && tap_go;
			if (state_q == sedr_pkg::ST_CLEAR) begin
				clr_cnt_q <= clr_cnt_q + 1'b1;
			end
			if (accept) begin
				div_cnt_q <= 4'd9;
			end else if (state_q == sedr_pkg::ST_DIV) begin
				div_cnt_q <= div_cnt_q - 4'd1;
			end
			if (state_q == sedr_pkg::ST_DIV) begin
				taps_q <= '0;
			end else if (state_q == sedr_pkg::ST_TAP && tap_go) begin
				taps_q <= taps_q + 1'b1;
			end
			if (fin_load) begin
				sp_q <= sp_q + 1'b1;
				ep_q <= (PW'(ep_inc) >= PW'(delay_length_q)) ? '0 : ep_inc;
			end
			if (fin_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mix_l_q <= $signed(s_tdata[47:32]);
			mix_r_q <= $signed(s_tdata[63:48]);
			last_q  <= s_tlast;
			rem_q   <= '0;
		end else if (state_q == sedr_pkg::ST_DIV) begin
			rem_q  <= div_rem[4:0];
			quot_q <= {quot_q[7:0], div_ge};
			if (div_cnt_q == 4'd0) begin
				step_q <= {1'b0, quot_q, div_ge} + 11'd1;
				dist_q <= '0;
				gain_q <= sedr_pkg::GAIN_ONE;
			end
		end else if (state_q == sedr_pkg::ST_TAP && tap_go) begin
			dist_q  <= dist_q + step_q;
			gain_q  <= gain_nx;
			gain_s1 <= gain_q;
		end
		if (fin_load) begin
			m_tdata_q <= {out_r, out_l};
			m_tlast_q <= last_q;
		end
	end

	// history ring: new sample at accept, zeros during clearing
	always_comb begin
		if (state_q == sedr_pkg::ST_CLEAR) begin
			hist_we = ({1'b0, clr_cnt_q} < (CLR_W + 1)'(HISTORY_DEPTH));
			hist_wa = clr_cnt_q[HAW-1:0];
			hist_wd = '0;
		end else begin
			hist_we = accept;
			hist_wa = sp_q;
			hist_wd = s_tdata[31:0];
		end
	end

	assign hist_re = (state_q == sedr_pkg::ST_TAP) && tap_go;
	assign hist_ra = sp_q - dist_x[HAW-1:0];

	always_ff @(posedge clk) begin
		if (hist_we) begin
			hist_mem[hist_wa] <= hist_wd;
		end
		if (hist_re) begin
			hist_rd_q <= hist_mem[hist_ra];
		end
	end

	// echo ring: read at accept, write back when the item finishes
	always_comb begin
		if (state_q == sedr_pkg::ST_CLEAR) begin
			echo_we = ({1'b0, clr_cnt_q} < (CLR_W + 1)'(ECHO_DEPTH));
			echo_wa = clr_cnt_q[EAW-1:0];
			echo_wd = '0;
		end else begin
			echo_we = (state_q == sedr_pkg::ST_FIN);
			echo_wa = ep_q;
			echo_wd = {er, el};
		end
	end

	assign echo_re = accept;

	always_ff @(posedge clk) begin
		if (echo_we) begin
			echo_mem[echo_wa] <= echo_wd;
		end
		if (echo_re) begin
			echo_rd_q <= echo_mem[ep_q];
		end
	end

	sedr_tap_lane #(
		.MAX_TAPS (MAX_TAPS)
	) u_lane_l (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (lane_ctrl),
		.sample  ($signed(hist_rd_q[15:0])),
		.gain    (gain_s1),
		.tap_sum (tsum_l)
	);

	sedr_tap_lane #(
		.MAX_TAPS (MAX_TAPS)
	) u_lane_r (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (lane_ctrl),
		.sample  ($signed(hist_rd_q[31:16])),
		.gain    (gain_s1),
		.tap_sum (tsum_r)
	);

	sedr_smoother #(
		.MAX_TAPS (MAX_TAPS)
	) u_smoother (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (sm_start),
		.feedback_gain (feedback_gain_q),
		.x_left        ($signed(echo_rd_q[15:0])),
		.x_right       ($signed(echo_rd_q[31:16])),
		.reso_left     (tsum_l),
		.reso_right    (tsum_r),
		.done          (sm_done),
		.echo_left     (el),
		.echo_right    (er)
	);

	assign out_l_sum = {mix_l_q[15], mix_l_q} + {el[15], el};
	assign out_r_sum = {mix_r_q[15], mix_r_q} + {er[15], er};

	always_comb begin
		if (out_l_sum[16] != out_l_sum[15]) begin
			out_l = out_l_sum[16] ? 16'h8000 : 16'h7fff;
		end else begin
			out_l = out_l_sum[15:0];
		end
		if (out_r_sum[16] != out_r_sum[15]) begin
			out_r = out_r_sum[16] ? 16'h8000 : 16'h7fff;
		end else begin
			out_r = out_r_sum[15:0];
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tlast  = m_tlast_q;

endmodule

// File: rtl/sedr_checker.sv
// ----------------------------------------------------------------------------
// sedr_checker
// port-level checks of the stereo echo delay, bound to the top level
// ----------------------------------------------------------------------------
`include "stereo_echo_delay_with_resonance_defines.svh"

module sedr_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata,
	input logic        m_tlast
);

	logic [2:0] pend_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			pend_q <= pend_q + 3'(s_tvalid && s_tready) - 3'(m_tvalid && m_tready);
		end
	end

	`SEDR_ASSERT_NXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast), "result item changed while stalled")
	`SEDR_ASSERT_IMP(a_pend_max, clk, arst_n, 1'b1, pend_q <= 3'd2, "more than two items in flight")
	`SEDR_ASSERT_IMP(a_out_owned, clk, arst_n, m_tvalid, pend_q != 3'd0, "result item without an input item")
	`SEDR_ASSERT_NXT(a_one_item, clk, arst_n, s_tvalid && s_tready, !s_tready, "second item taken while one is at work")

endmodule

bind stereo_echo_delay_with_resonance sedr_checker u_sedr_checker (.*);
